@@ rtl/stable_priority_queue_macros.svh @@
// assertion macros for the priority queue
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, masked during reset
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spq_pkg.sv @@
`default_nettype none
package spq_pkg;

  localparam int CapacityDefault = 16;
  localparam int DataW = 32;
  localparam int PrioW = 32;
  localparam int TotalW = 5;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_PEEK = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]              action;
    logic [DataW-1:0]        item_data;
    logic signed [PrioW-1:0] item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [DataW-1:0]  front_data;
    logic [1:0]        status;
    logic [TotalW-1:0] entry_total;
  } spq_out_t;

  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic signed [PrioW-1:0] new_priority;
    logic [DataW-1:0]        new_data;
  } spq_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/spq_cell.sv @@
`default_nettype none
module spq_cell
  import spq_pkg::*;
(
  input  wire logic                    clk,
  input  wire spq_ctrl_t               ctrl,
  input  wire logic                    occupied,
  input  wire logic                    left_keep,
  input  wire logic signed [PrioW-1:0] left_priority,
  input  wire logic [DataW-1:0]        left_data,
  input  wire logic signed [PrioW-1:0] right_priority,
  input  wire logic [DataW-1:0]        right_data,
  output logic                         keep,
  output logic signed [PrioW-1:0]      priority_q,
  output logic [DataW-1:0]             data_q
);

  // entry stays put when it ranks at or above the newcomer
  assign keep = occupied && (priority_q >= ctrl.new_priority);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (!keep) begin
        if (left_keep) begin
          priority_q <= ctrl.new_priority;
          data_q     <= ctrl.new_data;
        end else begin
          priority_q <= left_priority;
          data_q     <= left_data;
        end
      end
    end else if (ctrl.remove) begin
      priority_q <= right_priority;
      data_q     <= right_data;
    end
  end

endmodule
`default_nettype wire

@@ rtl/stable_priority_queue.sv @@
// Sorted priority queue of up to CAPACITY entries (signed priority plus data word),
// highest priority at the front, equal priorities served in arrival order. It is
// built as a row of cells that all compare against the incoming priority at once
// and shift one place right on insert or one place left on remove. The result of every
// transaction (insert, remove or peek) is registered, and a new one is accepted
// every cycle while the result register is free or being drained. Insert on a full
// queue reports status full; remove or peek on an empty queue reports status empty.
`default_nettype none
`include "stable_priority_queue_macros.svh"
module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int CAPACITY = CapacityDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire spq_in_t  in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output spq_out_t      out_item
);

  localparam int CountW = $clog2(CAPACITY + 1);

  logic              accept;
  logic              is_insert;
  logic              is_remove;
  logic              full;
  logic              empty;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_next;
  spq_ctrl_t         ctrl;
  spq_out_t          result;

  logic                    keep_v     [CAPACITY];
  logic signed [PrioW-1:0] prio_v     [CAPACITY];
  logic [DataW-1:0]        data_v     [CAPACITY];

  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;
  assign is_insert = (in_item.action == ACT_INSERT);
  assign is_remove = (in_item.action == ACT_REMOVE);
  assign full      = (count == CountW'(CAPACITY));
  assign empty     = (count == '0);

  assign ctrl.insert       = accept && is_insert && !full;
  assign ctrl.remove       = accept && is_remove && !empty;
  assign ctrl.new_priority = in_item.item_priority;
  assign ctrl.new_data     = in_item.item_data;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                    occupied;
      logic                    left_keep;
      logic signed [PrioW-1:0] left_priority;
      logic [DataW-1:0]        left_data;
      logic signed [PrioW-1:0] right_priority;
      logic [DataW-1:0]        right_data;

      assign occupied = (CountW'(i) < count);

      if (i == 0) begin : g_head
        assign left_keep     = 1'b1;
        assign left_priority = '0;
        assign left_data     = '0;
      end else begin : g_body
        assign left_keep     = keep_v[i-1];
        assign left_priority = prio_v[i-1];
        assign left_data     = data_v[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
        assign right_priority = '0;
        assign right_data     = '0;
      end else begin : g_inner
        assign right_priority = prio_v[i+1];
        assign right_data     = data_v[i+1];
      end

      spq_cell u_cell (
        .clk           (clk),
        .ctrl          (ctrl),
        .occupied      (occupied),
        .left_keep     (left_keep),
        .left_priority (left_priority),
        .left_data     (left_data),
        .right_priority(right_priority),
        .right_data    (right_data),
        .keep          (keep_v[i]),
        .priority_q    (prio_v[i]),
        .data_q        (data_v[i])
      );
    end
  endgenerate

  always_comb begin
    count_next        = count;
    result.front_data = '0;
    result.status     = ST_OK;
    if (is_insert) begin
      if (full) begin
        result.status = ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else if (empty) begin
      result.status = ST_EMPTY;
    end else begin
      result.front_data = data_v[0];
      if (is_remove) begin
        count_next = count - 1'b1;
      end
    end
    result.entry_total = TotalW'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= result;
    end
  end

  `SPQ_ASSERT_NOW(a_count_bound, 1'b1, count <= CountW'(CAPACITY), "count above capacity")
  `SPQ_ASSERT_NEXT(a_full_insert, accept && is_insert && full,
    out_item.status == ST_FULL && count == $past(count), "full insert mishandled")
  `SPQ_ASSERT_NEXT(a_remove_count, accept && is_remove && !empty,
    count == $past(count) - 1'b1, "remove did not drop count")
  `SPQ_ASSERT_NOW(a_empty_zero, out_valid && out_item.status == ST_EMPTY,
    out_item.front_data == '0 && out_item.entry_total == '0, "empty result not zero")

endmodule
`default_nettype wire
